@@ hdl/scmg_pkg.sv @@
// Shared types and constants of the S-curve membership grader.
// Used by every module under hdl; depends on nothing else.
package scmg_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 15;
  localparam int unsigned GRADE_BITS      = 16;
  localparam int unsigned ADDR_BITS       = 4;
  localparam int unsigned DATA_BITS       = 32;

  localparam logic [DATA_BITS-1:0] LOWER_RESET  = 32'd0;
  localparam logic [DATA_BITS-1:0] MIDDLE_RESET = 32'd32768;
  localparam logic [DATA_BITS-1:0] UPPER_RESET  = 32'd65535;

  localparam logic [1:0] REG_LOWER  = 2'd0;
  localparam logic [1:0] REG_MIDDLE = 2'd1;
  localparam logic [1:0] REG_UPPER  = 2'd2;

  localparam logic [1:0] BAND_BELOW = 2'd0;
  localparam logic [1:0] BAND_LOWER = 2'd1;
  localparam logic [1:0] BAND_UPPER = 2'd2;
  localparam logic [1:0] BAND_ABOVE = 2'd3;

  typedef struct packed {
    logic       valid;
    logic       falling;
    logic [1:0] band;
  } ctl_t;

endpackage

@@ hdl/s_curve_membership_grade.sv @@
// Top level of the S-curve membership grader: edge registers, band decode,
// divider cell chain and shaping stage. Depends on scmg_pkg, scmg_div_cell, scmg_shape.
//
// The grader takes one sample in every clock cycle; busy is always low, so a
// transfer happens whenever start is high. Each result is registered through
// the input stage, the divider chain of FRAC_BITS cells that each produce one
// quotient bit, the multiply stage and the output stage. The result strobe lasts
// one cycle and cannot be held off by the receiver. Edge registers may only be
// written while no sample is in flight.
module s_curve_membership_grade #(
  parameter int unsigned SAMPLE_BITS = scmg_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = scmg_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  input  logic                            req_type_i,
  output logic                            grade_valid_o,
  output logic [scmg_pkg::GRADE_BITS-1:0] grade_o,
  output logic [1:0]                      band_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [scmg_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [scmg_pkg::DATA_BITS-1:0]  pwdata,
  output logic [scmg_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);
  import scmg_pkg::*;

  localparam logic [GRADE_BITS-1:0] ONE_GRADE = GRADE_BITS'(64'(1) << FRAC_BITS);

  logic [SAMPLE_BITS-1:0] lower_q, lower_d;
  logic [SAMPLE_BITS-1:0] middle_q, middle_d;
  logic [SAMPLE_BITS-1:0] upper_q, upper_d;
  logic [1:0]             reg_idx;
  logic                   wr_en;

  ctl_t                   in_ctl;
  ctl_t                   ctl_w  [FRAC_BITS+1];
  logic [SAMPLE_BITS-1:0] span_w [FRAC_BITS+1];
  logic [SAMPLE_BITS-1:0] rem_w  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]   quo_w  [FRAC_BITS+1];
  ctl_t                   s0_ctl_q;
  logic [SAMPLE_BITS-1:0] s0_span_q, s0_span_d;
  logic [SAMPLE_BITS-1:0] s0_rem_q, s0_rem_d;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    lower_d  = lower_q;
    middle_d = middle_q;
    upper_d  = upper_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_LOWER:  lower_d  = pwdata[SAMPLE_BITS-1:0];
        REG_MIDDLE: middle_d = pwdata[SAMPLE_BITS-1:0];
        REG_UPPER:  upper_d  = pwdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOWER:  prdata = DATA_BITS'(lower_q);
      REG_MIDDLE: prdata = DATA_BITS'(middle_q);
      REG_UPPER:  prdata = DATA_BITS'(upper_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q  <= SAMPLE_BITS'(LOWER_RESET);
      middle_q <= SAMPLE_BITS'(MIDDLE_RESET);
      upper_q  <= SAMPLE_BITS'(UPPER_RESET);
    end else begin
      lower_q  <= lower_d;
      middle_q <= middle_d;
      upper_q  <= upper_d;
    end
  end

  always_comb begin
    in_ctl.valid   = start && !busy;
    in_ctl.falling = req_type_i;
    if (sample_i <= lower_q) begin
      in_ctl.band = BAND_BELOW;
    end else if (sample_i >= upper_q) begin
      in_ctl.band = BAND_ABOVE;
    end else if (sample_i <= middle_q) begin
      in_ctl.band = BAND_LOWER;
    end else begin
      in_ctl.band = BAND_UPPER;
    end
    s0_span_d = upper_q - lower_q;
    s0_rem_d  = sample_i - lower_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
    end else begin
      s0_ctl_q <= in_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_span_q <= s0_span_d;
    s0_rem_q  <= s0_rem_d;
  end

  assign ctl_w[0]  = s0_ctl_q;
  assign span_w[0] = s0_span_q;
  assign rem_w[0]  = s0_rem_q;
  assign quo_w[0]  = '0;

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
    scmg_div_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_w[k]),
      .span_i(span_w[k]),
      .rem_i (rem_w[k]),
      .quo_i (quo_w[k]),
      .ctl_o (ctl_w[k+1]),
      .span_o(span_w[k+1]),
      .rem_o (rem_w[k+1]),
      .quo_o (quo_w[k+1])
    );
  end

  scmg_shape #(
    .FRAC_BITS(FRAC_BITS)
  ) u_shape (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_w[FRAC_BITS]),
    .pos_i  (quo_w[FRAC_BITS]),
    .valid_o(grade_valid_o),
    .grade_o(grade_o),
    .band_o (band_o)
  );

`ifndef SYNTHESIS
  a_strobe_from_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grade_valid_o |-> $past(ctl_w[FRAC_BITS].valid, 2))
    else $error("Result strobe without an item leaving the divider chain.");

  a_outer_band_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grade_valid_o && (band_o == BAND_BELOW || band_o == BAND_ABOVE))
      |-> (grade_o == '0 || grade_o == ONE_GRADE))
    else $error("Outer band result is neither zero nor one.");

  a_entry_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> s0_ctl_q.valid)
    else $error("Accepted transfer did not enter the input stage.");
`endif

endmodule

@@ hdl/scmg_div_cell.sv @@
// One cell of the restoring divider chain: produces one quotient bit per item.
// Depends on scmg_pkg for the control struct.
module scmg_div_cell #(
  parameter int unsigned SAMPLE_BITS = scmg_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = scmg_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scmg_pkg::ctl_t         ctl_i,
  input  logic [SAMPLE_BITS-1:0] span_i,
  input  logic [SAMPLE_BITS-1:0] rem_i,
  input  logic [FRAC_BITS-1:0]   quo_i,
  output scmg_pkg::ctl_t         ctl_o,
  output logic [SAMPLE_BITS-1:0] span_o,
  output logic [SAMPLE_BITS-1:0] rem_o,
  output logic [FRAC_BITS-1:0]   quo_o
);
  import scmg_pkg::*;

  logic [SAMPLE_BITS:0]   shifted;
  logic [SAMPLE_BITS:0]   diff;
  logic                   take;
  ctl_t                   ctl_q;
  logic [SAMPLE_BITS-1:0] span_q, span_d;
  logic [SAMPLE_BITS-1:0] rem_q, rem_d;
  logic [FRAC_BITS-1:0]   quo_q, quo_d;

  always_comb begin
    shifted = {rem_i, 1'b0};
    diff    = shifted - {1'b0, span_i};
    take    = (shifted >= {1'b0, span_i});
    rem_d   = take ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
    quo_d   = {quo_i[FRAC_BITS-2:0], take};
    span_d  = span_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign ctl_o  = ctl_q;
  assign span_o = span_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;

endmodule

@@ hdl/scmg_shape.sv @@
// Curve shaping after the divider: one registered multiply, then saturation.
// Depends on scmg_pkg for the control struct, band codes and grade width.
module scmg_shape #(
  parameter int unsigned FRAC_BITS = scmg_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scmg_pkg::ctl_t                ctl_i,
  input  logic [FRAC_BITS-1:0]          pos_i,
  output logic                          valid_o,
  output logic [scmg_pkg::GRADE_BITS-1:0] grade_o,
  output logic [1:0]                    band_o
);
  import scmg_pkg::*;

  localparam int unsigned OW = FRAC_BITS + 1;
  localparam int unsigned PW = 2 * OW;
  localparam int unsigned GW = FRAC_BITS + 2;
  localparam logic [OW-1:0] ONE_OP = OW'(1) << FRAC_BITS;
  localparam logic [GW-1:0] ONE_G  = GW'(1) << FRAC_BITS;

  logic [OW-1:0] pos_ext;
  logic [OW-1:0] rest;
  logic [OW-1:0] op_a;
  logic [OW-1:0] op_b;
  logic [PW-1:0] prod_d, prod_q;
  ctl_t          ctl_q;
  logic [GW-1:0] scaled;
  logic [GW-1:0] capped;
  logic [GW-1:0] level;
  logic          valid_q;
  logic [GRADE_BITS-1:0] grade_q, grade_d;
  logic [1:0]    band_q;

  always_comb begin
    pos_ext = {1'b0, pos_i};
    rest    = ONE_OP - pos_ext;
    if (ctl_i.falling) begin
      op_a = pos_ext;
      op_b = rest;
    end else if (ctl_i.band == BAND_LOWER) begin
      op_a = pos_ext;
      op_b = pos_ext;
    end else begin
      op_a = rest;
      op_b = rest;
    end
    prod_d = op_a * op_b;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_comb begin
    scaled = GW'(prod_q >> (FRAC_BITS - 1));
    capped = (scaled > ONE_G) ? ONE_G : scaled;
    case (ctl_q.band)
      BAND_BELOW: level = ctl_q.falling ? ONE_G : '0;
      BAND_ABOVE: level = ctl_q.falling ? '0 : ONE_G;
      default: begin
        if (ctl_q.falling) begin
          level = (ctl_q.band == BAND_LOWER) ? (ONE_G - capped) : capped;
        end else if (ctl_q.band == BAND_LOWER) begin
          level = capped;
        end else begin
          level = (scaled >= ONE_G) ? '0 : (ONE_G - scaled);
        end
      end
    endcase
    grade_d = GRADE_BITS'(level);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    grade_q <= grade_d;
    band_q  <= ctl_q.band;
  end

  assign valid_o = valid_q;
  assign grade_o = grade_q;
  assign band_o  = band_q;

endmodule

@@ verif/scmg_grade_checker.sv @@
// Checker of the S-curve membership grader: tracks the edge registers from the APB port,
// predicts grade and band for every accepted sample and compares them with the results.
// Depends on scmg_pkg for register indexes, band codes and default widths.
module scmg_grade_checker #(
  parameter int unsigned SAMPLE_BITS = scmg_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = scmg_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  input  logic                            req_type_i,
  input  logic                            grade_valid_i,
  input  logic [scmg_pkg::GRADE_BITS-1:0] grade_i,
  input  logic [1:0]                      band_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [scmg_pkg::ADDR_BITS-1:0]  paddr_i,
  input  logic [scmg_pkg::DATA_BITS-1:0]  pwdata_i,
  output int                              errors_o,
  output int                              pending_o,
  output int                              checked_o
);
  import scmg_pkg::*;

  typedef struct packed {
    logic [GRADE_BITS-1:0] grade;
    logic [1:0]            band;
  } grade_rsp_t;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  logic [SAMPLE_BITS-1:0] lower_edge;
  logic [SAMPLE_BITS-1:0] middle_point;
  logic [SAMPLE_BITS-1:0] upper_edge;
  grade_rsp_t             grade_exp_q[$];

  function automatic grade_rsp_t grade_of(input logic [SAMPLE_BITS-1:0] x, input logic falling,
                                          input logic [SAMPLE_BITS-1:0] lo,
                                          input logic [SAMPLE_BITS-1:0] mid,
                                          input logic [SAMPLE_BITS-1:0] hi);
    grade_rsp_t  rsp;
    logic [63:0] xw, low, span, pos, comp, sq, prod, g;
    xw = x;
    low = lo;
    g = 64'd0;
    if (x <= lo) rsp.band = BAND_BELOW;
    else if (x >= hi) rsp.band = BAND_ABOVE;
    else if (x <= mid) rsp.band = BAND_LOWER;
    else rsp.band = BAND_UPPER;
    if (rsp.band == BAND_BELOW) begin
      g = falling ? ONE : 64'd0;
    end else if (rsp.band == BAND_ABOVE) begin
      g = falling ? 64'd0 : ONE;
    end else begin
      span = hi;
      span = span - low;
      pos = ((xw - low) << FRAC_BITS) / span;
      if (pos > ONE) pos = ONE;
      comp = ONE - pos;
      if (!falling) begin
        if (rsp.band == BAND_LOWER) begin
          sq = (64'd2 * pos * pos) >> FRAC_BITS;
          g = (sq > ONE) ? ONE : sq;
        end else begin
          sq = (64'd2 * comp * comp) >> FRAC_BITS;
          g = (sq >= ONE) ? 64'd0 : ONE - sq;
        end
      end else begin
        prod = (64'd2 * pos * comp) >> FRAC_BITS;
        if (prod > ONE) prod = ONE;
        g = (rsp.band == BAND_LOWER) ? ONE - prod : prod;
      end
    end
    rsp.grade = g[GRADE_BITS-1:0];
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    grade_rsp_t exp_rsp;
    if (!rst_ni) begin
      lower_edge   <= LOWER_RESET[SAMPLE_BITS-1:0];
      middle_point <= MIDDLE_RESET[SAMPLE_BITS-1:0];
      upper_edge   <= UPPER_RESET[SAMPLE_BITS-1:0];
      grade_exp_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_BITS-1:2])
          REG_LOWER:  lower_edge   <= pwdata_i[SAMPLE_BITS-1:0];
          REG_MIDDLE: middle_point <= pwdata_i[SAMPLE_BITS-1:0];
          REG_UPPER:  upper_edge   <= pwdata_i[SAMPLE_BITS-1:0];
          default: ;
        endcase
      end
      if (grade_valid_i) begin
        if (grade_exp_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got grade %0d band %0d",
                   $time, grade_i, band_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_rsp = grade_exp_q.pop_front();
          checked_o <= checked_o + 1;
          if (grade_i !== exp_rsp.grade || band_i !== exp_rsp.band) begin
            $display("%0t result mismatch: expected grade %0d band %0d, got grade %0d band %0d",
                     $time, exp_rsp.grade, exp_rsp.band, grade_i, band_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        grade_exp_q.push_back(grade_of(sample_i, req_type_i, lower_edge, middle_point,
                                       upper_edge));
      end
      pending_o <= grade_exp_q.size();
    end
  end

endmodule

@@ verif/tb_s_curve_membership_grade.sv @@
// Testbench top of the S-curve membership grader: clock, reset, APB edge writes and
// sample stimulus, with the verdict. Depends on scmg_pkg, s_curve_membership_grade
// and scmg_grade_checker.
module tb_s_curve_membership_grade;
  import scmg_pkg::*;

  localparam logic [1:0] REG_SPARE      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         NUM_SETTINGS   = 10;
  localparam int         ITEMS_PER_SET  = 58;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [SAMPLE_BITS_DEF-1:0] sample;
  logic                      req_type;
  logic                      grade_valid;
  logic [GRADE_BITS-1:0]     grade;
  logic [1:0]                band;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_BITS-1:0]      paddr;
  logic [DATA_BITS-1:0]      pwdata;
  logic [DATA_BITS-1:0]      prdata;
  logic                      pready;
  int                        errors;
  int                        expected_count;
  int                        checked;
  int                        stall_cycles;
  int                        samples_sent;
  int                        settings_used;
  bit                        gaps_on;
  logic [15:0]               cfg_lo, cfg_mid, cfg_hi;

  s_curve_membership_grade u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .sample_i     (sample),
    .req_type_i   (req_type),
    .grade_valid_o(grade_valid),
    .grade_o      (grade),
    .band_o       (band),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  scmg_grade_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .sample_i     (sample),
    .req_type_i   (req_type),
    .grade_valid_i(grade_valid),
    .grade_i      (grade),
    .band_i       (band),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .errors_o     (errors),
    .pending_o    (expected_count),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || grade_valid || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [15:0] x, input logic falling);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start    <= 1'b1;
    sample   <= x;
    req_type <= falling;
    @(posedge clk_i iff !busy);
    samples_sent++;
  endtask

  // Lowers start and waits until every predicted grade has been checked.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (expected_count != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    logic [DATA_BITS-1:0] wdata;
    wdata = $urandom();
    wdata[15:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i iff pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_edges(input logic [15:0] lo, input logic [15:0] mid,
                             input logic [15:0] hi);
    write_reg(REG_LOWER, lo);
    write_reg(REG_MIDDLE, mid);
    write_reg(REG_UPPER, hi);
    cfg_lo = lo;
    cfg_mid = mid;
    cfg_hi = hi;
    settings_used++;
  endtask

  task automatic pick_edges(input int mode);
    int lo, mid, hi;
    case (mode)
      0: begin
        lo = 0;
        hi = 65535;
        case ($urandom_range(0, 2))
          0: mid = 0;
          1: mid = 65535;
          default: mid = $urandom_range(0, 65535);
        endcase
      end
      1: begin
        lo = $urandom_range(0, 65535);
        hi = lo;
        mid = $urandom_range(0, 65535);
      end
      2: begin
        hi = $urandom_range(0, 65000);
        lo = $urandom_range(hi + 1, 65535);
        mid = $urandom_range(0, 65535);
      end
      3: begin
        lo = $urandom_range(1000, 30000);
        hi = $urandom_range(lo + 1, 60000);
        mid = $urandom_range(0, 1) ? $urandom_range(0, lo) : $urandom_range(hi, 65535);
      end
      4: begin
        lo = $urandom_range(0, 65000);
        hi = lo + $urandom_range(1, 3);
        mid = $urandom_range(lo, hi);
      end
      default: begin
        lo = $urandom_range(0, 60000);
        hi = $urandom_range(lo + 1, 65535);
        mid = $urandom_range(lo, hi);
      end
    endcase
    write_edges(lo[15:0], mid[15:0], hi[15:0]);
  endtask

  // Mostly samples strictly inside the edges, where the division and the
  // quadratic pieces are exercised, plus boundary neighbors and noise.
  function automatic logic [15:0] pick_sample();
    logic [15:0] base;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && int'(cfg_lo) + 1 < int'(cfg_hi)) begin
      return 16'($urandom_range(int'(cfg_lo) + 1, int'(cfg_hi) - 1));
    end else if (sel < 8) begin
      case ($urandom_range(0, 2))
        0: base = cfg_lo;
        1: base = cfg_mid;
        default: base = cfg_hi;
      endcase
      return base + 16'($urandom_range(0, 2)) - 16'd1;
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    sample   = '0;
    req_type = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    stall_cycles  = 0;
    samples_sent  = 0;
    settings_used = 0;
    gaps_on  = 1'b1;
    cfg_lo   = LOWER_RESET[15:0];
    cfg_mid  = MIDDLE_RESET[15:0];
    cfg_hi   = UPPER_RESET[15:0];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset edges: extremes of the sample, the middle point and its neighbor.
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b1);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd65535, 1'b1);
    send_sample(16'd32768, 1'b0);
    send_sample(16'd32768, 1'b1);
    send_sample(16'd32769, 1'b0);
    send_sample(16'd32769, 1'b1);
    send_sample(16'd1, 1'b1);
    send_sample(16'd65534, 1'b0);
    send_sample(16'd16384, 1'b1);
    send_sample(16'd49152, 1'b0);

    // Off-center middle point; a write to the unused index must be ignored.
    wait_drained();
    write_edges(16'd1000, 16'd1500, 16'd5000);
    write_reg(REG_SPARE, 16'hBEEF);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1001, 1'b1);
    send_sample(16'd1499, 1'b0);
    send_sample(16'd1500, 1'b1);
    send_sample(16'd1501, 1'b0);
    send_sample(16'd4999, 1'b1);
    send_sample(16'd5000, 1'b0);

    // Edges out of order: only the outer bands can occur.
    wait_drained();
    write_edges(16'd40000, 16'd20000, 16'd100);
    send_sample(16'd50, 1'b0);
    send_sample(16'd100, 1'b1);
    send_sample(16'd20000, 1'b0);
    send_sample(16'd40000, 1'b1);
    send_sample(16'd40001, 1'b0);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_drained();
      gaps_on = (s < NUM_SETTINGS - 2);
      pick_edges(s < 6 ? s : $urandom_range(0, 8));
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        if (s == 3 && i == ITEMS_PER_SET / 2) wait_drained();
        send_sample(pick_sample(), 1'($urandom_range(0, 1)));
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Graded %0d samples over %0d edge settings, both curves, with idle bursts",
             samples_sent, settings_used);
    $display("and a full drain pause; %0d results compared on grade and band.", checked);
    if (errors == 0 && expected_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/scmg_pkg.sv
hdl/scmg_div_cell.sv
hdl/scmg_shape.sv
hdl/s_curve_membership_grade.sv
verif/scmg_grade_checker.sv
verif/tb_s_curve_membership_grade.sv
